/* rtl/lfu_pkg.sv */
// Shared types and constants for the LFU cache replacement unit.
// Used by lfu_cmp_unit and lfu_cache_replacement_unit; depends on nothing.
package lfu_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W    = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int COUNT_W   = 32;
  localparam int STAMP_W   = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CAP_W-1:0]   CAP_MAX   = CAP_W'(ENTRIES);
  localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(ENTRIES - 1);

  // Request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Result of one slot compare
  typedef struct packed {
    logic key_eq;   // slot key equals the request key
    logic better;   // slot is a better victim than the current candidate
  } cmp_res_t;

endpackage

/* rtl/lfu_cmp_unit.sv */
// Shared compare unit: checks one slot per cycle for key match and victim order.
// Depends on lfu_pkg.
module lfu_cmp_unit (
  input  logic [lfu_pkg::KEY_W-1:0]   slot_key,
  input  logic [lfu_pkg::COUNT_W-1:0] slot_count,
  input  logic [lfu_pkg::STAMP_W-1:0] slot_stamp,
  input  logic [lfu_pkg::KEY_W-1:0]   req_key,
  input  logic                        have_best,
  input  logic [lfu_pkg::COUNT_W-1:0] best_count,
  input  logic [lfu_pkg::STAMP_W-1:0] best_stamp,
  output lfu_pkg::cmp_res_t           res
);

  logic count_lt;
  logic count_eq;
  logic stamp_lt;

  // Lower count wins; equal counts fall back to the older stamp
  always_comb begin
    count_lt   = slot_count < best_count;
    count_eq   = slot_count == best_count;
    stamp_lt   = slot_stamp < best_stamp;
    res.key_eq = slot_key == req_key;
    res.better = !have_best || count_lt || (count_eq && stamp_lt);
  end

endmodule

/* rtl/lfu_cache_replacement_unit.sv */
// Top level of the LFU cache replacement unit: slot store, scan sequencer, result register.
// Depends on lfu_pkg and lfu_cmp_unit.
//
// Usage:
//   Requests enter on the input channel (in_valid / in_stall) as req_type,
//   lookup_key and write_value. Each request yields exactly one result word
//   on the output channel (out_valid / out_stall): hit, read_value, evicted
//   and evicted_key.
//   Each accepted request is first scanned slot by slot, one slot per cycle
//   through the single compare unit, then an update step writes the chosen
//   slot and loads the result register. With capacity zero the scan is
//   skipped and the request goes straight to the update step. The input
//   stalls for the whole scan and update, so a new request is taken only
//   once the unit is back in idle, after the last result has been loaded.
//   A result waiting in the output register does not block the next scan;
//   only the update step waits for the register to drain.
//   capacity_in_use is written with cfg_we; the user must do so only while the
//   unit is idle, as the unit does not enforce it. Reset clears all slot valid
//   bits, the access clock and the result valid bit, and sets the capacity to 16.
module lfu_cache_replacement_unit (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0] capacity_in_use,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      req_type,
  input  logic [lfu_pkg::KEY_W-1:0] lookup_key,
  input  logic [lfu_pkg::VAL_W-1:0] write_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic [lfu_pkg::VAL_W-1:0] read_value,
  output logic                      evicted,
  output logic [lfu_pkg::KEY_W-1:0] evicted_key
);

  // Slot store
  logic [lfu_pkg::ENTRIES-1:0] slot_valid;
  logic [lfu_pkg::KEY_W-1:0]   slot_key   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::VAL_W-1:0]   slot_value [lfu_pkg::ENTRIES];
  logic [lfu_pkg::COUNT_W-1:0] slot_count [lfu_pkg::ENTRIES];
  logic [lfu_pkg::STAMP_W-1:0] slot_stamp [lfu_pkg::ENTRIES];
  logic [lfu_pkg::STAMP_W-1:0] access_clock;
  logic [lfu_pkg::CAP_W-1:0]   cap_reg;

  // Sequencer
  lfu_pkg::state_t state;
  lfu_pkg::state_t state_next;
  logic [lfu_pkg::IDX_W-1:0] idx;

  // Latched request
  logic                      req_put;
  logic [lfu_pkg::KEY_W-1:0] req_key;
  logic [lfu_pkg::VAL_W-1:0] req_val;
  logic                      req_skip;

  // Scan results
  logic                        found;
  logic [lfu_pkg::IDX_W-1:0]   match_idx;
  logic [lfu_pkg::VAL_W-1:0]   match_value;
  logic [lfu_pkg::COUNT_W-1:0] match_count;
  logic                        have_best;
  logic [lfu_pkg::IDX_W-1:0]   best_idx;
  logic [lfu_pkg::KEY_W-1:0]   best_key;
  logic [lfu_pkg::COUNT_W-1:0] best_count;
  logic [lfu_pkg::STAMP_W-1:0] best_stamp;
  logic                        have_free;
  logic [lfu_pkg::IDX_W-1:0]   free_idx;
  logic [lfu_pkg::FILL_W-1:0]  used;

  // Control
  logic                      accept;
  logic                      scan_en;
  logic                      out_free;
  logic                      commit;
  logic [lfu_pkg::CAP_W-1:0] cap_eff;
  lfu_pkg::cmp_res_t         cmp;

  // Update decision
  logic                        do_evict;
  logic                        do_insert;
  logic [lfu_pkg::IDX_W-1:0]   ins_idx;
  logic [lfu_pkg::STAMP_W-1:0] stamp_next;
  logic [lfu_pkg::COUNT_W-1:0] count_next;

  // Clamp the configured capacity to the slot count
  assign cap_eff = (cap_reg > lfu_pkg::CAP_MAX) ? lfu_pkg::CAP_MAX : cap_reg;

  // Compare the slot under the scan pointer
  lfu_cmp_unit u_cmp (
    .slot_key   (slot_key[idx]),
    .slot_count (slot_count[idx]),
    .slot_stamp (slot_stamp[idx]),
    .req_key    (req_key),
    .have_best  (have_best),
    .best_count (best_count),
    .best_stamp (best_stamp),
    .res        (cmp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (cap_eff == '0) ? lfu_pkg::ST_UPDATE : lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (idx == lfu_pkg::IDX_LAST) begin
          state_next = lfu_pkg::ST_UPDATE;
        end
      end
      lfu_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_next = lfu_pkg::ST_IDLE;
        end
      end
      default: state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = 1'b1;
    scan_en  = 1'b0;
    commit   = 1'b0;
    unique case (state)
      lfu_pkg::ST_IDLE:   in_stall = 1'b0;
      lfu_pkg::ST_SCAN:   scan_en  = 1'b1;
      lfu_pkg::ST_UPDATE: commit   = out_free;
      default:            in_stall = 1'b1;
    endcase
  end

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  // Decide what the update step writes
  always_comb begin
    do_evict   = 1'b0;
    do_insert  = 1'b0;
    ins_idx    = free_idx;
    stamp_next = access_clock + lfu_pkg::STAMP_W'(1);
    count_next = (match_count == lfu_pkg::COUNT_MAX) ? match_count
                                                     : match_count + lfu_pkg::COUNT_W'(1);
    if (!req_skip && !found && (req_put == lfu_pkg::REQ_PUT)) begin
      if ((lfu_pkg::CAP_W'(used) >= cap_eff) && have_best) begin
        do_evict  = 1'b1;
        do_insert = 1'b1;
        ins_idx   = best_idx;
      end else if (have_free) begin
        do_insert = 1'b1;
      end
    end
  end

  // Sequencer state and scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx <= '0;
      end else if (scan_en) begin
        idx <= idx + lfu_pkg::IDX_W'(1);
      end
    end
  end

  // Capture the request and clear the scan results, then gather them during the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      req_put   <= req_type;
      req_key   <= lookup_key;
      req_val   <= write_value;
      req_skip  <= (cap_eff == '0);
      found     <= 1'b0;
      have_best <= 1'b0;
      have_free <= 1'b0;
      used      <= '0;
    end else if (scan_en) begin
      if (slot_valid[idx]) begin
        used <= used + lfu_pkg::FILL_W'(1);
        if (!found && cmp.key_eq) begin
          found       <= 1'b1;
          match_idx   <= idx;
          match_value <= slot_value[idx];
          match_count <= slot_count[idx];
        end
        if (cmp.better) begin
          have_best  <= 1'b1;
          best_idx   <= idx;
          best_key   <= slot_key[idx];
          best_count <= slot_count[idx];
          best_stamp <= slot_stamp[idx];
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        free_idx  <= idx;
      end
    end
  end

  // Configuration register, valid bits and access clock
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg      <= lfu_pkg::CAP_W'(16);
      slot_valid   <= '0;
      access_clock <= '0;
    end else begin
      if (cfg_we) begin
        cap_reg <= capacity_in_use;
      end
      if (commit && !req_skip) begin
        if (found || do_insert) begin
          access_clock <= stamp_next;
        end
        if (do_insert) begin
          slot_valid[ins_idx] <= 1'b1;
        end
      end
    end
  end

  // Slot payload writes
  always_ff @(posedge clk) begin
    if (commit && !req_skip) begin
      if (found) begin
        slot_count[match_idx] <= count_next;
        slot_stamp[match_idx] <= stamp_next;
        if (req_put == lfu_pkg::REQ_PUT) begin
          slot_value[match_idx] <= req_val;
        end
      end else if (do_insert) begin
        slot_key[ins_idx]   <= req_key;
        slot_value[ins_idx] <= req_val;
        slot_count[ins_idx] <= lfu_pkg::COUNT_W'(1);
        slot_stamp[ins_idx] <= stamp_next;
      end
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit         <= !req_skip && found;
      read_value  <= (!req_skip && found && (req_put == lfu_pkg::REQ_GET)) ? match_value : '0;
      evicted     <= do_evict;
      evicted_key <= do_evict ? best_key : '0;
    end
  end

endmodule
